>>> design/sm3he_pkg.sv
// ---------------------------------------------------------------------------
// sm3he_pkg
// Shared types, constants and functions of the SM3 hash engine.
// ---------------------------------------------------------------------------
package sm3he_pkg;

    typedef logic [31:0] t_word;

    // standard SM3 initial value, also the reset value of the IV registers
    localparam t_word IV_RESET [8] = '{
        32'h7380166f, 32'h4914b2b9, 32'h172442d7, 32'hda8a0600,
        32'ha96f30bc, 32'h163138aa, 32'he38dee4d, 32'hb0fb0e4e
    };

    localparam t_word T_LOW  = 32'h79cc4519;
    localparam t_word T_HIGH = 32'h7a879d8a;
    localparam logic [7:0] PAD_BYTE = 8'h80;

    // top-level sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_COMP,
        ST_PAD,
        ST_OUT
    } t_top_state;

    // padding step still to be pushed
    typedef enum logic [1:0] {
        PAD_EXTRA,
        PAD_ZERO,
        PAD_LENLO,
        PAD_DONE
    } t_pad_kind;

    // compression unit phases
    typedef enum logic [1:0] {
        CP_IDLE,
        CP_LOAD,
        CP_ROUND,
        CP_FIN
    } t_cmp_phase;

    // control from the sequencer to the compression unit
    typedef struct packed {
        logic start;
        logic load_iv;
    } t_cmp_ctl;

    // status back from the compression unit
    typedef struct packed {
        logic busy;
        logic done;
    } t_cmp_stat;

    function automatic t_word rotl(input t_word x, input logic [4:0] n);
        rotl = (x << n) | (x >> (6'd32 - {1'b0, n}));
    endfunction

    function automatic t_word perm0(input t_word x);
        perm0 = x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
    endfunction

    function automatic t_word perm1(input t_word x);
        perm1 = x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
    endfunction

    // round constant rotated by the round number
    function automatic t_word round_const(input logic [5:0] j);
        round_const = rotl((j < 6'd16) ? T_LOW : T_HIGH, j[4:0]);
    endfunction

endpackage

>>> design/sm3he_compress.sv
// ---------------------------------------------------------------------------
// sm3he_compress
// SM3 compression unit: loads a block from the buffer memory into a
// 16-word expansion window, runs 64 rounds at one per cycle and folds
// the result into the chaining value.
// ---------------------------------------------------------------------------
module sm3he_compress (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  sm3he_pkg::t_cmp_ctl   i_ctl,
    input  sm3he_pkg::t_word      i_iv [8],
    output logic [3:0]            o_rd_addr,
    input  sm3he_pkg::t_word      i_rd_data,
    output sm3he_pkg::t_cmp_stat  o_stat,
    output sm3he_pkg::t_word      o_cv [8]
);
    import sm3he_pkg::*;

    t_cmp_phase r_phase, n_phase;
    logic [5:0] r_cnt;
    t_word      r_cv  [8];
    t_word      r_reg [8];
    t_word      r_win [16];

    t_word a12, ss1, ss2, ff, gg, tt1, tt2, wj, wp, nw;

    // next phase
    always_comb begin
        n_phase = r_phase;
        case (r_phase)
            CP_IDLE:  if (i_ctl.start) n_phase = CP_LOAD;
            CP_LOAD:  if (r_cnt == 6'd16) n_phase = CP_ROUND;
            CP_ROUND: if (r_cnt == 6'd63) n_phase = CP_FIN;
            CP_FIN:   n_phase = CP_IDLE;
            default:  n_phase = CP_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_rd_addr   = r_cnt[3:0];
        o_stat.busy = (r_phase != CP_IDLE);
        o_stat.done = (r_phase == CP_FIN);
    end

    // one round
    always_comb begin
        wj  = r_win[0];
        wp  = r_win[0] ^ r_win[4];
        a12 = rotl(r_reg[0], 5'd12);
        ss1 = rotl(a12 + r_reg[4] + round_const(r_cnt), 5'd7);
        ss2 = ss1 ^ a12;
        if (r_cnt < 6'd16) begin
            ff = r_reg[0] ^ r_reg[1] ^ r_reg[2];
            gg = r_reg[4] ^ r_reg[5] ^ r_reg[6];
        end else begin
            ff = (r_reg[0] & r_reg[1]) | (r_reg[0] & r_reg[2]) | (r_reg[1] & r_reg[2]);
            gg = (r_reg[4] & r_reg[5]) | (~r_reg[4] & r_reg[6]);
        end
        tt1 = ff + r_reg[3] + ss2 + wp;
        tt2 = gg + r_reg[7] + ss1 + wj;
        nw  = perm1(wj ^ r_win[7] ^ rotl(r_win[13], 5'd15))
              ^ rotl(r_win[3], 5'd7) ^ r_win[10];
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= CP_IDLE;
            r_cnt   <= '0;
        end else begin
            r_phase <= n_phase;
            if (r_phase != n_phase) r_cnt <= '0;
            else if (r_phase != CP_IDLE) r_cnt <= r_cnt + 6'd1;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_ctl.load_iv) r_cv <= i_iv;
        if (r_phase == CP_IDLE && i_ctl.start) r_reg <= r_cv;
        // shift the window: loaded words, then expanded words
        if ((r_phase == CP_LOAD && r_cnt != 6'd0) || r_phase == CP_ROUND) begin
            for (int k = 0; k < 15; k++) r_win[k] <= r_win[k+1];
            r_win[15] <= (r_phase == CP_LOAD) ? i_rd_data : nw;
        end
        if (r_phase == CP_ROUND) begin
            r_reg[0] <= tt1;
            r_reg[1] <= r_reg[0];
            r_reg[2] <= rotl(r_reg[1], 5'd9);
            r_reg[3] <= r_reg[2];
            r_reg[4] <= perm0(tt2);
            r_reg[5] <= r_reg[4];
            r_reg[6] <= rotl(r_reg[5], 5'd19);
            r_reg[7] <= r_reg[6];
        end
        if (r_phase == CP_FIN) begin
            for (int k = 0; k < 8; k++) r_cv[k] <= r_cv[k] ^ r_reg[k];
        end
    end

    assign o_cv = r_cv;

endmodule

>>> design/sm3_hash_engine_core.sv
// ---------------------------------------------------------------------------
// sm3_hash_engine_core
// SM3 hash engine: gathers message words into a 16-word block memory,
// pads the final block and streams out the eight digest words.
// ---------------------------------------------------------------------------
// channel   dir  tdata                              tuser           tlast
// s_axis    in   [31:0] message_word,               valid_bytes     final_word
//                [63:32] length_offset_bytes
// m_axis    out  [31:0] digest_word                 digest_index    digest_last
// cfg       in   i_cfg_index selects init_word_a..h, i_cfg_data is the value
//
// A normal word is written into the block memory; a word that fills a block
// also starts a compression: block load into the expansion window, 64 rounds, fold.
// A final word is followed by its padding words, one or two block compressions,
// then eight digest items. The round loop of the compression unit sets the rate.
// Reset is synchronous; no clearing pass. Input is taken only when idle; a
// stalled digest item holds until taken.
// ---------------------------------------------------------------------------
module sm3_hash_engine_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [31:0] message_word, [63:32] length_offset_bytes
    input  logic [2:0]  s_axis_tuser,   // [2:0] valid_bytes
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] digest_word
    output logic [2:0]  m_axis_tuser,   // [2:0] digest_index
    output logic        m_axis_tlast,
    input  logic        i_cfg_wr_en,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    import sm3he_pkg::*;

    t_top_state r_state, n_state;
    t_pad_kind  r_pad, n_pad;
    logic       r_pad_active, n_pad_active;
    logic       r_first;
    logic [3:0] r_wpos;
    logic [2:0] r_oidx;
    logic [63:0] r_bc, n_bc;
    t_word      r_init [8];
    t_word      r_mem  [16];
    t_word      r_rd_data;

    logic       in_acc, out_acc;
    logic       push_en;
    t_word      push_data;
    logic [2:0] vbc;
    t_word      word_in;
    t_word      tail_word;
    logic [63:0] bits;

    t_cmp_ctl   cmp_ctl;
    t_cmp_stat  cmp_stat;
    logic [3:0] cmp_addr;
    t_word      cv [8];

    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign out_acc = m_axis_tvalid && m_axis_tready;
    assign word_in = s_axis_tdata[31:0];
    assign vbc     = (s_axis_tuser > 3'd4) ? 3'd4 : s_axis_tuser;
    assign bits    = {r_bc[60:0], 3'b000};

    // mask the tail and place the padding byte after the valid bytes of a partial word
    always_comb begin
        case (vbc)
            3'd0:    tail_word = {PAD_BYTE, 24'h0};
            3'd1:    tail_word = {word_in[31:24], PAD_BYTE, 16'h0};
            3'd2:    tail_word = {word_in[31:16], PAD_BYTE, 8'h0};
            3'd3:    tail_word = {word_in[31:8], PAD_BYTE};
            default: tail_word = word_in;
        endcase
    end

    // byte count of the message
    always_comb begin
        n_bc = (r_first ? {32'h0, s_axis_tdata[63:32]} : r_bc)
               + (s_axis_tlast ? {61'h0, vbc} : 64'd4);
    end

    // word pushed into the block memory
    always_comb begin
        push_en   = 1'b0;
        push_data = word_in;
        n_pad     = r_pad;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    push_en = 1'b1;
                    if (s_axis_tlast) begin
                        push_data = tail_word;
                        n_pad = (vbc == 3'd4) ? PAD_EXTRA : PAD_ZERO;
                    end
                end
            end
            ST_PAD: begin
                push_en = 1'b1;
                case (r_pad)
                    PAD_EXTRA: begin
                        push_data = {PAD_BYTE, 24'h0};
                        n_pad = PAD_ZERO;
                    end
                    PAD_ZERO: begin
                        if (r_wpos == 4'd14) begin
                            push_data = bits[63:32];
                            n_pad = PAD_LENLO;
                        end else begin
                            push_data = '0;
                        end
                    end
                    PAD_LENLO: begin
                        push_data = bits[31:0];
                        n_pad = PAD_DONE;
                    end
                    default: push_en = 1'b0;
                endcase
            end
            default: ;
        endcase
    end

    // next state
    always_comb begin
        n_state      = r_state;
        n_pad_active = r_pad_active;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_pad_active = s_axis_tlast;
                    if (r_wpos == 4'd15) n_state = ST_COMP;
                    else if (s_axis_tlast) n_state = ST_PAD;
                end
            end
            ST_PAD: begin
                if (r_wpos == 4'd15) n_state = ST_COMP;
            end
            ST_COMP: begin
                if (cmp_stat.done) begin
                    if (!r_pad_active) n_state = ST_IDLE;
                    else if (r_pad == PAD_DONE) n_state = ST_OUT;
                    else n_state = ST_PAD;
                end
            end
            ST_OUT: begin
                if (out_acc && r_oidx == 3'd7) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        s_axis_tready   = (r_state == ST_IDLE) && !cmp_stat.busy;
        m_axis_tvalid   = (r_state == ST_OUT);
        m_axis_tdata    = cv[r_oidx];
        m_axis_tuser    = r_oidx;
        m_axis_tlast    = (r_oidx == 3'd7);
        cmp_ctl.load_iv = in_acc && r_first;
        cmp_ctl.start   = push_en && (r_wpos == 4'd15);
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_pad        <= PAD_DONE;
            r_pad_active <= 1'b0;
            r_first      <= 1'b1;
            r_wpos       <= '0;
            r_oidx       <= '0;
            r_bc         <= '0;
        end else begin
            r_state      <= n_state;
            r_pad        <= n_pad;
            r_pad_active <= n_pad_active;
            if (push_en) r_wpos <= r_wpos + 4'd1;
            if (in_acc) begin
                r_first <= 1'b0;
                r_bc    <= n_bc;
            end
            if (out_acc) begin
                r_oidx <= r_oidx + 3'd1;
                if (r_oidx == 3'd7) begin
                    r_first <= 1'b1;
                    r_bc    <= '0;
                end
            end
        end
    end

    // IV registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init <= IV_RESET;
        end else if (i_cfg_wr_en) begin
            r_init[i_cfg_index] <= i_cfg_data;
        end
    end

    // block memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (push_en) r_mem[r_wpos] <= push_data;
        r_rd_data <= r_mem[cmp_addr];
    end

    sm3he_compress u_compress (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (cmp_ctl),
        .i_iv      (r_init),
        .o_rd_addr (cmp_addr),
        .i_rd_data (r_rd_data),
        .o_stat    (cmp_stat),
        .o_cv      (cv)
    );

endmodule

>>> design/sm3he_checker.sv
// ---------------------------------------------------------------------------
// sm3he_checker
// Port-level checks of the SM3 hash engine, bound to the top level.
// ---------------------------------------------------------------------------
module sm3he_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic [2:0]  m_axis_tuser,
    input logic        m_axis_tlast
);
    // no input is taken while the digest is being delivered
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input ready during digest output");

    // the last digest item is the eighth
    a_last_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser == 3'd7)))
        else $error("digest_last does not match index");

    // digest items follow back to back with rising index
    a_index_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && !m_axis_tlast)
        |=> (m_axis_tvalid && m_axis_tuser == $past(m_axis_tuser) + 3'd1))
        else $error("digest index sequence broken");

    // a stalled digest item holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled digest item changed");

endmodule

bind sm3_hash_engine_core sm3he_checker u_sm3he_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
